@@ rtl/itp_pkg.sv @@
// Shared types, character codes and digit decoding for the integer text parser.
package itp_pkg;

  typedef struct packed {
    logic signed [63:0] value;
    logic [15:0]        offset;
  } itp_result_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LX     = 8'h78;

  localparam logic [4:0] BASE_AUTO = 5'd0;
  localparam logic [4:0] BASE_OCT  = 5'd8;
  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] BASE_HEX  = 5'd16;

  // A non-digit decodes to the largest code, which no base admits.
  localparam logic [4:0] DIGIT_NONE = 5'd31;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'(DIGIT_NONE);
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA + 8'd10;
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 8'd10;
      end
      digit_of = d[4:0];
    end
  endfunction

endpackage

@@ rtl/itp_out_buf.sv @@
// Two-entry result buffer between the parse stage and the output channel.
module itp_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  itp_pkg::itp_result_t push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output itp_pkg::itp_result_t pop_data
);
  import itp_pkg::*;

  itp_result_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fill != 2'd0);
  assign space     = (fill != 2'd2);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/itp_core.sv @@
// Input register and per-character parse step with the string state.
module itp_core #(
  parameter int unsigned MAX_CHARS = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         char_in,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         base_cfg,
  input  logic               buf_space,
  output logic               res_valid,
  output itp_pkg::itp_result_t res
);
  import itp_pkg::*;

  localparam logic [15:0] COUNT_CAP =
    (MAX_CHARS < 65535) ? 16'(MAX_CHARS) : 16'hFFFF;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_DRAIN
  } phase_t;

  logic [7:0]  char_q;
  logic        char_vld;
  phase_t      phase;
  logic        neg;
  logic [4:0]  abase;
  logic [63:0] acc;
  logic [15:0] count;

  phase_t      phase_next;
  logic        neg_next;
  logic [4:0]  abase_next;
  logic [63:0] acc_next;
  logic [15:0] count_next;

  logic [4:0]  dig;
  logic [4:0]  first_base;
  logic [4:0]  dbase;
  logic        first_zero;
  logic        in_first;
  logic        is_ws;
  logic        is_sign;
  logic        is_x;
  logic        do_first;
  logic        do_digit;
  logic        dig_ok;
  logic [63:0] acc_mac;
  logic [15:0] count_bump;
  logic        emit;
  logic        fire;

  always_comb begin
    dig        = digit_of(char_q);
    is_ws      = (char_q == CH_SPACE) || (char_q == CH_TAB) || (char_q == CH_NL);
    is_sign    = (char_q == CH_PLUS) || (char_q == CH_MINUS);
    is_x       = (char_q == CH_LX) || (char_q == CH_UX);
    first_zero = (char_q == CH_ZERO) && ((base_cfg == BASE_AUTO) || (base_cfg == BASE_HEX));
    first_base = (base_cfg == BASE_AUTO) ? BASE_DEC : base_cfg;
    in_first   = (phase == PH_SPACE) || (phase == PH_SIGN);
    dbase      = in_first ? first_base : abase;
    dig_ok     = (dig < dbase);
    acc_mac    = (acc * 64'(dbase)) + 64'(dig);
    count_bump = (count < COUNT_CAP) ? (count + 16'd1) : count;
    do_first   = ((phase == PH_SPACE) && !is_ws && !is_sign) || (phase == PH_SIGN);
    do_digit   = (do_first && !first_zero) || (phase == PH_DIGITS) ||
                 ((phase == PH_ZERO) && !is_x);
  end

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    abase_next = abase;
    acc_next   = acc;
    count_next = count;
    emit       = 1'b0;
    if (char_q == CH_NUL) begin
      emit       = (phase != PH_DRAIN);
      phase_next = PH_SPACE;
      neg_next   = 1'b0;
      abase_next = 5'd0;
      acc_next   = 64'd0;
      count_next = 16'd0;
    end else begin
      unique case (phase)
        PH_SPACE: begin
          if (is_ws) begin
            count_next = count_bump;
          end else if (is_sign) begin
            neg_next   = (char_q == CH_MINUS);
            count_next = count_bump;
            abase_next = 5'd0;
            phase_next = PH_SIGN;
          end
        end
        PH_ZERO: begin
          phase_next = PH_DIGITS;
          if (is_x) begin
            abase_next = BASE_HEX;
            count_next = count_bump;
          end
        end
        default: ;
      endcase
      if (do_first) begin
        if (first_zero) begin
          abase_next = (base_cfg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
          acc_next   = 64'd0;
          count_next = count_bump;
          phase_next = PH_ZERO;
        end else begin
          abase_next = first_base;
          phase_next = PH_DIGITS;
        end
      end
      if (do_digit) begin
        if (dig_ok) begin
          acc_next   = acc_mac;
          count_next = count_bump;
        end else begin
          phase_next = PH_DRAIN;
          emit       = 1'b1;
        end
      end
    end
  end

  assign fire       = char_vld && (!emit || buf_space);
  assign in_ready   = !char_vld || fire;
  assign res_valid  = fire && emit;
  assign res.value  = neg ? $signed(64'd0 - acc) : $signed(acc);
  assign res.offset = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_vld <= 1'b0;
      char_q   <= CH_NUL;
      phase    <= PH_SPACE;
      neg      <= 1'b0;
      abase    <= 5'd0;
      acc      <= 64'd0;
      count    <= 16'd0;
    end else begin
      if (in_ready) begin
        char_vld <= in_valid;
        char_q   <= char_in;
      end
      if (fire) begin
        phase <= phase_next;
        neg   <= neg_next;
        abase <= abase_next;
        acc   <= acc_next;
        count <= count_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> buf_space)
    else $error("Result pushed into a full buffer.");

  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && (char_q == CH_NUL)) |=> ((phase == PH_SPACE) && (count == 16'd0) && !neg))
    else $error("End of string did not clear the parse state.");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_CAP)
    else $error("Character count passed its cap.");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(acc) && $stable(count))
    else $error("Parse state changed without a processed character.");
`endif

endmodule

@@ rtl/integer_text_parser.sv @@
// Top level of the streaming string-to-integer parser.
//
// Characters arrive one per beat on char_in (in_valid/in_ready); a NUL ends
// the string. Leading space, tab and newline are skipped, one sign is taken,
// and digits below the radix are accumulated modulo 2^64. The radix comes
// from number_base, written on the cfg_valid/cfg_ready channel while the
// block is idle, a rule for the user that the block itself does not enforce.
// Zero picks octal, hex or decimal from the prefix. One result beat
// (parsed_value, end_offset) leaves on out_valid/out_ready for the character
// that stops the number, or for the NUL if none did. An accepted character is
// held in the input register and parsed there; its result goes into the buffer.
// Throughput: one character per cycle while the buffer has room, set by the
// single parse stage whose multiply-accumulate updates the state for every
// character. A two-beat result buffer lets parsing continue while the
// receiver stalls; with the buffer full, a character that stops a number,
// or an ending NUL, waits in the input register and in_ready drops.
// Reset clears the string state, empties the buffer and sets the radix to 10.
module integer_text_parser #(
  parameter int unsigned MAX_CHARS = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         char_in,
  input  logic               in_valid,
  output logic               in_ready,
  output logic signed [63:0] parsed_value,
  output logic [15:0]        end_offset,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [4:0]         number_base,
  input  logic               cfg_valid,
  output logic               cfg_ready
);
  import itp_pkg::*;

  logic [4:0]  base_cfg;
  logic        res_valid;
  logic        buf_space;
  itp_result_t res;
  itp_result_t pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_cfg <= BASE_DEC;
    end else if (cfg_valid && cfg_ready) begin
      base_cfg <= number_base;
    end
  end

  itp_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .base_cfg  (base_cfg),
    .buf_space (buf_space),
    .res_valid (res_valid),
    .res       (res)
  );

  itp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (buf_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pop_data  (pop_data)
  );

  assign parsed_value = pop_data.value;
  assign end_offset   = pop_data.offset;

endmodule
